### hw/rtl/hrhp_pkg.sv
package hrhp_pkg;

  localparam int unsigned MAX_URI_BYTES    = 126;
  localparam int unsigned MAX_HEADER_BYTES = 2048;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  // lowercased method prefixes, first byte in the low bits
  localparam logic [23:0] PFX_GET  = 24'h746567;
  localparam logic [31:0] PFX_HEAD = 32'h64616568;
  localparam logic [31:0] PFX_POST = 32'h74736f70;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URI     = 3'd1,
    PH_VERSION = 3'd2,
    PH_GAP_KEY = 3'd3,
    PH_KEY     = 3'd4,
    PH_GAP_VAL = 3'd5,
    PH_VALUE   = 3'd6,
    PH_STOP    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    METH_NONE = 2'd0,
    METH_GET  = 2'd1,
    METH_HEAD = 2'd2,
    METH_POST = 2'd3
  } method_t;

  typedef enum logic [1:0] {
    TOK_NONE  = 2'd0,
    TOK_URI   = 2'd1,
    TOK_KEY   = 2'd2,
    TOK_VALUE = 2'd3
  } token_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_METHOD = 2'd1,
    ERR_LONG   = 2'd2
  } err_t;

  typedef struct packed {
    logic ws;
    logic cr;
    logic lf;
    logic space;
    logic colon;
    logic slash;
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] low;
    logic       new_req;
    cls_t       cls;
  } q_item_t;

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == CH_SPACE) || (b == CH_CR) || (b == CH_LF) || (b == CH_TAB);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b >= 8'h41 && b <= 8'h5a) ? (b + 8'd32) : b;
  endfunction

endpackage

### hw/rtl/hrhp_front.sv
module hrhp_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_new_request,
  output logic             push,
  output hrhp_pkg::q_item_t push_item,
  input  logic             q_ready
);
  import hrhp_pkg::*;

  // classify each byte once so the back end only tests flags
  assign in_ready              = q_ready;
  assign push                  = in_valid && q_ready;
  assign push_item.data        = in_data_byte;
  assign push_item.low         = to_lower(in_data_byte);
  assign push_item.new_req     = in_new_request;
  assign push_item.cls.ws      = is_ws(in_data_byte);
  assign push_item.cls.cr      = (in_data_byte == CH_CR);
  assign push_item.cls.lf      = (in_data_byte == CH_LF);
  assign push_item.cls.space   = (in_data_byte == CH_SPACE);
  assign push_item.cls.colon   = (in_data_byte == CH_COLON);
  assign push_item.cls.slash   = (in_data_byte == CH_SLASH);

endmodule

### hw/rtl/hrhp_queue.sv
module hrhp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hrhp_pkg::q_item_t push_item,
  output logic              q_ready,
  input  logic              pop,
  output logic              q_valid,
  output hrhp_pkg::q_item_t q_item
);
  import hrhp_pkg::*;

  q_item_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/hrhp_back.sv
module hrhp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  hrhp_pkg::q_item_t q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_token_kind,
  output logic              out_byte_valid,
  output logic [7:0]        out_out_byte,
  output logic              out_token_end,
  output logic [1:0]        out_method_code,
  output logic              out_request_done,
  output logic [1:0]        out_error_code
);
  import hrhp_pkg::*;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [1:0]  tp_r, tp_nxt;
  logic [31:0] prefix_r, prefix_nxt;
  logic [1:0]  mseen_r, mseen_nxt;
  logic [6:0]  ucnt_r, ucnt_nxt;
  logic [11:0] tcnt_r, tcnt_nxt;
  logic [7:0]  hb_r, hb_nxt;
  logic        hv_r, hv_nxt;

  // output register
  logic        ov_r;
  logic [1:0]  kind_r, kind_nxt;
  logic        bv_r, bv_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        tend_r, tend_nxt;
  logic        done_r;
  logic [1:0]  err_r, err_nxt;

  // state as seen by this item (a new request starts from reset values)
  phase_t      ph;
  logic [1:0]  tp;
  logic [31:0] prefix;
  logic [1:0]  mseen;
  logic [6:0]  ucnt;
  logic [11:0] tcnt;
  logic [7:0]  hb;
  logic        hv;

  logic        nr;
  cls_t        c;
  logic        active, over, proc, done, early_err;
  logic [1:0]  code;
  logic        uri_hv;

  assign nr     = q_item.new_req;
  assign c      = q_item.cls;
  assign ph     = nr ? PH_METHOD : phase_r;
  assign tp     = nr ? 2'd0  : tp_r;
  assign prefix = nr ? 32'd0 : prefix_r;
  assign mseen  = nr ? 2'd0  : mseen_r;
  assign ucnt   = nr ? 7'd0  : ucnt_r;
  assign tcnt   = nr ? 12'd0 : tcnt_r;
  assign hb     = nr ? 8'd0  : hb_r;
  assign hv     = nr ? 1'b0  : hv_r;

  assign pop       = q_valid && (!ov_r || out_ready);
  assign active    = (ph != PH_STOP);
  assign over      = (tcnt >= 12'(MAX_HEADER_BYTES));
  assign proc      = active && !over;
  assign done      = proc && (tp == 2'd3) && c.lf;
  assign early_err = done && (ph == PH_METHOD || ph == PH_URI);
  assign uri_hv    = (ucnt == 7'd0) ? c.slash : hv;

  always_comb begin
    if ((prefix[23:0] == PFX_GET)) code = METH_GET;
    else if (prefix == PFX_HEAD)   code = METH_HEAD;
    else if (prefix == PFX_POST)   code = METH_POST;
    else                           code = METH_NONE;
  end

  // next phase
  always_comb begin
    phase_nxt = ph;
    if (!proc || done) begin
      phase_nxt = PH_STOP;
    end else begin
      unique case (ph)
        PH_METHOD:  if (c.space) phase_nxt = (code == METH_NONE) ? PH_STOP : PH_URI;
        PH_URI:     if (c.space) phase_nxt = PH_VERSION;
        PH_VERSION: if (c.lf) phase_nxt = PH_GAP_KEY;
        PH_GAP_KEY: if (!c.ws) phase_nxt = PH_KEY;
        PH_KEY:     if (c.colon || c.ws) phase_nxt = PH_GAP_VAL;
        PH_GAP_VAL: if (!c.ws) phase_nxt = PH_VALUE;
        PH_VALUE:   if (c.lf) phase_nxt = PH_GAP_KEY;
        default:    phase_nxt = PH_STOP;
      endcase
    end
  end

  // token outputs and datapath state
  always_comb begin
    kind_nxt   = TOK_NONE;
    bv_nxt     = 1'b0;
    ob_nxt     = 8'd0;
    tend_nxt   = 1'b0;
    err_nxt    = ERR_NONE;
    tp_nxt     = tp;
    prefix_nxt = prefix;
    mseen_nxt  = mseen;
    ucnt_nxt   = ucnt;
    tcnt_nxt   = tcnt;
    hb_nxt     = hb;
    hv_nxt     = hv;
    if (active && over) begin
      err_nxt = ERR_LONG;
    end else if (proc) begin
      if (tcnt != 12'hfff) tcnt_nxt = tcnt + 12'd1;
      case (tp)
        2'd0:    tp_nxt = c.cr ? 2'd1 : 2'd0;
        2'd1:    tp_nxt = c.lf ? 2'd2 : (c.cr ? 2'd1 : 2'd0);
        2'd2:    tp_nxt = c.cr ? 2'd3 : 2'd0;
        default: tp_nxt = c.lf ? 2'd0 : (c.cr ? 2'd1 : 2'd0);
      endcase
      if (early_err) begin
        err_nxt   = ERR_METHOD;
        mseen_nxt = METH_NONE;
      end else begin
        unique case (ph)
          PH_METHOD: begin
            if (c.space) begin
              if (code == METH_NONE) begin
                err_nxt = ERR_METHOD;
              end else begin
                mseen_nxt = code;
                ucnt_nxt  = 7'd0;
                hv_nxt    = 1'b0;
              end
            end else if (tcnt < 12'd4) begin
              prefix_nxt[{tcnt[1:0], 3'b000} +: 8] = q_item.low;
            end
          end
          PH_URI: begin
            if (c.space) begin
              if (hv) begin
                kind_nxt = TOK_URI;
                tend_nxt = 1'b1;
              end
              hv_nxt = 1'b0;
            end else begin
              hv_nxt = uri_hv;
              if (uri_hv && ucnt < 7'(MAX_URI_BYTES)) begin
                kind_nxt = TOK_URI;
                bv_nxt   = 1'b1;
                ob_nxt   = q_item.data;
              end
              if (ucnt != 7'd127) ucnt_nxt = ucnt + 7'd1;
            end
          end
          PH_VERSION: begin
          end
          PH_GAP_KEY: begin
            if (!c.ws) begin
              kind_nxt = TOK_KEY;
              bv_nxt   = 1'b1;
              ob_nxt   = q_item.low;
            end
          end
          PH_KEY: begin
            kind_nxt = TOK_KEY;
            if (c.colon || c.ws) begin
              tend_nxt = 1'b1;
            end else begin
              bv_nxt = 1'b1;
              ob_nxt = q_item.low;
            end
          end
          PH_GAP_VAL: begin
            if (!c.ws) begin
              hb_nxt = q_item.data;
              hv_nxt = 1'b1;
            end
          end
          PH_VALUE: begin
            if (c.lf) begin
              kind_nxt = TOK_VALUE;
              tend_nxt = 1'b1;
              if (hv && !is_ws(hb)) begin
                bv_nxt = 1'b1;
                ob_nxt = hb;
              end
              hv_nxt = 1'b0;
              hb_nxt = 8'd0;
            end else begin
              if (hv) begin
                kind_nxt = TOK_VALUE;
                bv_nxt   = 1'b1;
                ob_nxt   = hb;
              end
              hb_nxt = q_item.data;
              hv_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_METHOD;
      tp_r     <= 2'd0;
      prefix_r <= 32'd0;
      mseen_r  <= 2'd0;
      ucnt_r   <= 7'd0;
      tcnt_r   <= 12'd0;
      hb_r     <= 8'd0;
      hv_r     <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (pop) begin
        phase_r  <= phase_nxt;
        tp_r     <= tp_nxt;
        prefix_r <= prefix_nxt;
        mseen_r  <= mseen_nxt;
        ucnt_r   <= ucnt_nxt;
        tcnt_r   <= tcnt_nxt;
        hb_r     <= hb_nxt;
        hv_r     <= hv_nxt;
        ov_r     <= 1'b1;
      end else if (out_ready) begin
        ov_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r          <= kind_nxt;
      bv_r            <= bv_nxt;
      ob_r            <= ob_nxt;
      tend_r          <= tend_nxt;
      out_method_code <= mseen_nxt;
      done_r          <= done;
      err_r           <= err_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_token_kind   = kind_r;
  assign out_byte_valid   = bv_r;
  assign out_out_byte     = ob_r;
  assign out_token_end    = tend_r;
  assign out_request_done = done_r;
  assign out_error_code   = err_r;

`ifndef SYNTHESIS
  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> ov_r)
    else $error("popped item did not reach output register");
  a_err_no_method: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && err_r == ERR_METHOD |-> out_method_code == METH_NONE)
    else $error("method error with method code set");
  a_byte_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && bv_r |-> kind_r != TOK_NONE && !done_r)
    else $error("token byte without kind");
  a_stop_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (done || err_nxt != ERR_NONE) |=> phase_r == PH_STOP)
    else $error("parser not stopped after end or error");
`endif

endmodule

### hw/rtl/http_request_header_parser_top.sv
// HTTP request header parser.
// Input channel: one raw request byte per item (in_data_byte), with
// in_new_request set on the first byte of each request to restart the parse.
// Output channel: exactly one result item per input item, in order. A result
// carries at most one token byte (URI byte, lowercased header key byte or
// header value byte), plus token end, the method found so far, request done
// on the LF of CR LF CR LF, and an error code.
// Structure: the front classifies each byte (whitespace, CR, LF, colon,
// slash, lowercase copy) and writes it to a two-entry queue; the back pops
// one entry per cycle while its output register is empty or being read,
// advances the parser and loads the output register.
// Throughput: one item per cycle while out_ready holds, set by the parser
// update in the back end; with a stalled receiver the queue and output
// register keep taking items until both are full, then in_ready drops.
// Header values lag one byte through a hold register, so a value byte is
// reported on the result of the byte after it.
// Reset (rst_n low, synchronous) empties queue and output register and puts
// the parser in the method phase with all counters cleared.
module http_request_header_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_new_request,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_token_kind,
  output logic       out_byte_valid,
  output logic [7:0] out_out_byte,
  output logic       out_token_end,
  output logic [1:0] out_method_code,
  output logic       out_request_done,
  output logic [1:0] out_error_code
);
  import hrhp_pkg::*;

  logic    push;
  q_item_t push_item;
  logic    q_ready;
  logic    pop;
  logic    q_valid;
  q_item_t q_item;

  // byte classifier
  hrhp_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_new_request (in_new_request),
    .push           (push),
    .push_item      (push_item),
    .q_ready        (q_ready)
  );

  // decouples intake from the parser
  hrhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // parser state machine and output register
  hrhp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_byte_valid   (out_byte_valid),
    .out_out_byte     (out_out_byte),
    .out_token_end    (out_token_end),
    .out_method_code  (out_method_code),
    .out_request_done (out_request_done),
    .out_error_code   (out_error_code)
  );

endmodule
